FILE: hw/rtl/itlu_pkg.sv
// ----------------------------------------------------------------------------
// itlu_pkg
// Shared types and constants for the interpolating table lookup.
// ----------------------------------------------------------------------------
package itlu_pkg;

  localparam int MAX_POINTS_DEF = 32;
  localparam int AXIS_BITS_DEF  = 16;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int CNT_W   = 6;
  localparam int CELL_W  = 8;
  localparam int STAT_W  = 2;

  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(2);

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_INTERP = 2'd0,
    STAT_LOW    = 2'd1,
    STAT_HIGH   = 2'd2
  } stat_t;

  // control that travels alongside the stage 2, divider and multiply stages
  typedef struct packed {
    logic  valid;
    stat_t status;
  } ctl_t;

endpackage

FILE: hw/rtl/itlu_if.sv
// ----------------------------------------------------------------------------
// itlu_in_if / itlu_out_if
// Valid/ready channels carrying lookup/load beats and result beats.
// ----------------------------------------------------------------------------
interface itlu_in_if #(
  parameter int AXIS_W = 16,
  parameter int IDX_W  = 5
);
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [IDX_W-1:0]          point_index;
  logic signed [AXIS_W-1:0]  axis_value;
  logic [7:0]                cell_value;
  logic signed [AXIS_W-1:0]  x;

  modport source (output valid, action, point_index, axis_value, cell_value, x,
                  input ready);
  modport sink   (input valid, action, point_index, axis_value, cell_value, x,
                  output ready);
endinterface

interface itlu_out_if #(
  parameter int IDX_W = 5
);
  logic             valid;
  logic             ready;
  logic [7:0]       result;
  logic [IDX_W-1:0] segment_index;
  logic [1:0]       clamp_status;

  modport source (output valid, result, segment_index, clamp_status, input ready);
  modport sink   (input valid, result, segment_index, clamp_status, output ready);
endinterface

FILE: hw/rtl/itlu_ram.sv
// ----------------------------------------------------------------------------
// itlu_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module itlu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem_r[raddr_a];
      rdata_b <= mem_r[raddr_b];
    end
  end

endmodule

FILE: hw/rtl/itlu_seg.sv
// ----------------------------------------------------------------------------
// itlu_seg
// Breakpoint compare, segment encode and table read (stages 1 and 2).
// ----------------------------------------------------------------------------
module itlu_seg #(
  parameter int MAX_POINTS = 32,
  parameter int AXIS_W     = 16,
  parameter int IDX_W      = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_take,
  input  logic                       in_action,
  input  logic [IDX_W-1:0]           in_index,
  input  logic signed [AXIS_W-1:0]   in_axis,
  input  logic [7:0]                 in_cell,
  input  logic signed [AXIS_W-1:0]   in_x,
  input  logic [IDX_W-1:0]           nm1,
  output itlu_pkg::ctl_t             s2_ctl,
  output logic signed [AXIS_W-1:0]   s2_x,
  output logic [IDX_W-1:0]           s2_idx,
  output logic signed [AXIS_W-1:0]   s2_a0,
  output logic signed [AXIS_W-1:0]   s2_a1,
  output logic [7:0]                 s2_c0,
  output logic [7:0]                 s2_c1
);
  import itlu_pkg::*;

  localparam int RW = AXIS_W + CELL_W;

  logic signed [AXIS_W-1:0] axis_r [MAX_POINTS];
  logic [MAX_POINTS-1:0]    ge_nxt;
  logic                     idx_ok;

  // stage 1
  logic                     s1_vld_r;
  logic                     s1_act_r;
  logic [IDX_W-1:0]         s1_index_r;
  logic signed [AXIS_W-1:0] s1_axis_r;
  logic [7:0]               s1_cell_r;
  logic signed [AXIS_W-1:0] s1_x_r;
  logic [MAX_POINTS-1:0]    s1_ge_r;
  logic [IDX_W-1:0]         s1_nm1_r;

  logic [IDX_W-1:0] seg_i;
  logic [IDX_W-1:0] seg_i1;
  stat_t            seg_stat;
  logic             found;

  // stage 2
  ctl_t                     s2_ctl_r;
  logic signed [AXIS_W-1:0] s2_x_r;
  logic [IDX_W-1:0]         s2_idx_r;
  logic [RW-1:0]            rd_a;
  logic [RW-1:0]            rd_b;

  assign idx_ok = (int'(in_index) < MAX_POINTS);

  // compare against the table as it stands when the beat is taken
  always_comb begin
    for (int k = 0; k < MAX_POINTS; k++) begin
      ge_nxt[k] = (in_x >= axis_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && in_action == ACT_LOAD && idx_ok) begin
      axis_r[in_index] <= in_axis;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_act_r   <= in_action;
      s1_index_r <= in_index;
      s1_axis_r  <= in_axis;
      s1_cell_r  <= in_cell;
      s1_x_r     <= in_x;
      s1_ge_r    <= ge_nxt;
      s1_nm1_r   <= nm1;
    end
  end

  // segment encode: clamp high wins, then clamp low, then first bracket
  always_comb begin
    found = 1'b0;
    seg_i = '0;
    for (int k = MAX_POINTS - 2; k >= 0; k--) begin
      if (k < int'(s1_nm1_r) && s1_ge_r[k] && !s1_ge_r[k+1]) begin
        found = 1'b1;
        seg_i = IDX_W'(k);
      end
    end
    if (s1_ge_r[s1_nm1_r]) begin
      seg_i    = s1_nm1_r;
      seg_stat = STAT_HIGH;
    end else if (!s1_ge_r[0]) begin
      seg_i    = '0;
      seg_stat = STAT_LOW;
    end else if (found) begin
      seg_stat = STAT_INTERP;
    end else begin
      seg_i    = s1_nm1_r;
      seg_stat = STAT_HIGH;
    end
    seg_i1 = (int'(seg_i) == MAX_POINTS - 1) ? seg_i : seg_i + 1'b1;
  end

  itlu_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_POINTS),
    .AW    (IDX_W)
  ) u_ram (
    .clk     (clk),
    .we      (adv && s1_vld_r && s1_act_r == ACT_LOAD &&
              int'(s1_index_r) < MAX_POINTS),
    .waddr   (s1_index_r),
    .wdata   ({s1_axis_r, s1_cell_r}),
    .re      (adv),
    .raddr_a (seg_i),
    .raddr_b (seg_i1),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r.valid <= 1'b0;
    end else if (adv) begin
      s2_ctl_r.valid <= s1_vld_r && s1_act_r == ACT_LOOKUP;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ctl_r.status <= seg_stat;
      s2_x_r          <= s1_x_r;
      s2_idx_r        <= seg_i;
    end
  end

  assign s2_ctl = s2_ctl_r;
  assign s2_x   = s2_x_r;
  assign s2_idx = s2_idx_r;
  assign s2_a0  = rd_a[RW-1:CELL_W];
  assign s2_c0  = rd_a[CELL_W-1:0];
  assign s2_a1  = rd_b[RW-1:CELL_W];
  assign s2_c1  = rd_b[CELL_W-1:0];

endmodule

FILE: hw/rtl/itlu_div.sv
// ----------------------------------------------------------------------------
// itlu_div
// Pipelined restoring divider for the segment fraction, one bit per stage.
// ----------------------------------------------------------------------------
module itlu_div #(
  parameter int AXIS_W = 16,
  parameter int FRAC_W = 16,
  parameter int IDX_W  = 5
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  itlu_pkg::ctl_t            i_ctl,
  input  logic signed [AXIS_W-1:0]  i_x,
  input  logic [IDX_W-1:0]          i_idx,
  input  logic signed [AXIS_W-1:0]  i_a0,
  input  logic signed [AXIS_W-1:0]  i_a1,
  input  logic [7:0]                i_c0,
  input  logic [7:0]                i_c1,
  output itlu_pkg::ctl_t            o_ctl,
  output logic [IDX_W-1:0]          o_idx,
  output logic [7:0]                o_c0,
  output logic [7:0]                o_c1,
  output logic [FRAC_W-1:0]         o_t
);
  import itlu_pkg::*;

  localparam int RW = AXIS_W + 1;

  ctl_t             ctl_r [FRAC_W+1];
  logic [IDX_W-1:0] idx_r [FRAC_W+1];
  logic [7:0]       c0_r  [FRAC_W+1];
  logic [7:0]       c1_r  [FRAC_W+1];
  logic [RW-1:0]    rem_r [FRAC_W+1];
  logic [RW-1:0]    den_r [FRAC_W+1];
  logic [FRAC_W-1:0] q_r  [FRAC_W+1];

  logic [RW-1:0] rem0;
  logic [RW-1:0] den0;

  // clamped beats divide 0 by 1 so the fraction comes out zero
  always_comb begin
    if (i_ctl.status == STAT_INTERP) begin
      rem0 = RW'($signed({i_x[AXIS_W-1], i_x}) - $signed({i_a0[AXIS_W-1], i_a0}));
      den0 = RW'($signed({i_a1[AXIS_W-1], i_a1}) - $signed({i_a0[AXIS_W-1], i_a0}));
    end else begin
      rem0 = '0;
      den0 = RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0].valid <= 1'b0;
    end else if (adv) begin
      ctl_r[0].valid <= i_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r[0].status <= i_ctl.status;
      idx_r[0] <= i_idx;
      c0_r[0]  <= i_c0;
      c1_r[0]  <= i_c1;
      rem_r[0] <= rem0;
      den_r[0] <= den0;
      q_r[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= FRAC_W; k++) begin : g_step
    logic [RW:0]   rem2;
    logic          qbit;
    logic [RW-1:0] rem_nxt;

    always_comb begin
      rem2    = {rem_r[k-1], 1'b0};
      qbit    = (rem2 >= {1'b0, den_r[k-1]});
      rem_nxt = qbit ? RW'(rem2 - {1'b0, den_r[k-1]}) : RW'(rem2);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k].valid <= 1'b0;
      end else if (adv) begin
        ctl_r[k].valid <= ctl_r[k-1].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ctl_r[k].status <= ctl_r[k-1].status;
        idx_r[k] <= idx_r[k-1];
        c0_r[k]  <= c0_r[k-1];
        c1_r[k]  <= c1_r[k-1];
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_r[k-1];
        q_r[k]   <= {q_r[k-1][FRAC_W-2:0], qbit};
      end
    end
  end

  assign o_ctl = ctl_r[FRAC_W];
  assign o_idx = idx_r[FRAC_W];
  assign o_c0  = c0_r[FRAC_W];
  assign o_c1  = c1_r[FRAC_W];
  assign o_t   = q_r[FRAC_W];

endmodule

FILE: hw/rtl/interp_table_lookup_u8_top.sv
// ----------------------------------------------------------------------------
// interp_table_lookup_u8_top
// 1-D breakpoint table with linear interpolation of 8-bit cells.
// ----------------------------------------------------------------------------
// channel   dir  handshake        payload
// in_bus    in   valid/ready      action, point_index, axis_value, cell_value, x
// out_bus   out  valid/ready      result, segment_index, clamp_status
// cfg_*     in   cfg_wr_en        cfg_wr_data = point_count
//
// One beat enters per cycle while the pipeline is not stalled; the lookup depth
// is set by the one-bit-per-stage fraction divider. Loads give no beat.
// Reset clears every valid bit and sets point_count to 2; table contents are
// undefined until loaded. One stall signal freezes the whole pipeline while a
// result waits on out_bus.ready, so nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module interp_table_lookup_u8_top #(
  parameter int MAX_POINTS = itlu_pkg::MAX_POINTS_DEF,
  parameter int AXIS_BITS  = itlu_pkg::AXIS_BITS_DEF,
  parameter int FRAC_BITS  = itlu_pkg::FRAC_BITS_DEF,
  parameter int IDX_W      = $clog2(MAX_POINTS)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  itlu_in_if.sink                     in_bus,
  itlu_out_if.source                  out_bus,
  input  logic                        cfg_wr_en,
  input  logic [itlu_pkg::CNT_W-1:0]  cfg_wr_data
);
  import itlu_pkg::*;

  localparam int PW = FRAC_BITS + CELL_W + 2;

  logic [CNT_W-1:0] cnt_r;
  logic [IDX_W-1:0] nm1;
  logic             adv;
  logic             in_take;

  ctl_t                        s2_ctl;
  logic signed [AXIS_BITS-1:0] s2_x;
  logic [IDX_W-1:0]            s2_idx;
  logic signed [AXIS_BITS-1:0] s2_a0;
  logic signed [AXIS_BITS-1:0] s2_a1;
  logic [7:0]                  s2_c0;
  logic [7:0]                  s2_c1;

  ctl_t              dv_ctl;
  logic [IDX_W-1:0]  dv_idx;
  logic [7:0]        dv_c0;
  logic [7:0]        dv_c1;
  logic [FRAC_BITS-1:0] dv_t;

  ctl_t                 mul_ctl_r;
  logic [IDX_W-1:0]     mul_idx_r;
  logic [7:0]           mul_c0_r;
  logic signed [PW-1:0] mul_prod_r;
  logic signed [PW-1:0] prod_nxt;
  logic signed [PW-1:0] acc;

  logic             out_vld_r;
  logic [7:0]       out_res_r;
  logic [IDX_W-1:0] out_idx_r;
  stat_t            out_stat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CNT_RESET;
    end else if (cfg_wr_en) begin
      cnt_r <= cfg_wr_data;
    end
  end

  // zero acts as one, anything above the table size as the table size
  always_comb begin
    if (cnt_r == '0) begin
      nm1 = '0;
    end else if (int'(cnt_r) > MAX_POINTS) begin
      nm1 = IDX_W'(MAX_POINTS - 1);
    end else begin
      nm1 = IDX_W'(cnt_r - 1'b1);
    end
  end

  assign adv          = !out_vld_r || out_bus.ready;
  assign in_bus.ready = adv;
  assign in_take      = in_bus.valid && adv;

  itlu_seg #(
    .MAX_POINTS (MAX_POINTS),
    .AXIS_W     (AXIS_BITS),
    .IDX_W      (IDX_W)
  ) u_seg (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_take   (in_take),
    .in_action (in_bus.action),
    .in_index  (in_bus.point_index),
    .in_axis   (in_bus.axis_value),
    .in_cell   (in_bus.cell_value),
    .in_x      (in_bus.x),
    .nm1       (nm1),
    .s2_ctl    (s2_ctl),
    .s2_x      (s2_x),
    .s2_idx    (s2_idx),
    .s2_a0     (s2_a0),
    .s2_a1     (s2_a1),
    .s2_c0     (s2_c0),
    .s2_c1     (s2_c1)
  );

  itlu_div #(
    .AXIS_W (AXIS_BITS),
    .FRAC_W (FRAC_BITS),
    .IDX_W  (IDX_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .i_ctl (s2_ctl),
    .i_x   (s2_x),
    .i_idx (s2_idx),
    .i_a0  (s2_a0),
    .i_a1  (s2_a1),
    .i_c0  (s2_c0),
    .i_c1  (s2_c1),
    .o_ctl (dv_ctl),
    .o_idx (dv_idx),
    .o_c0  (dv_c0),
    .o_c1  (dv_c1),
    .o_t   (dv_t)
  );

  // t * (v1 - v0), then v0 * 2^F added in the output stage
  assign prod_nxt = PW'($signed({1'b0, dv_t}) *
                        ($signed({1'b0, dv_c1}) - $signed({1'b0, dv_c0})));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_ctl_r.valid <= 1'b0;
    end else if (adv) begin
      mul_ctl_r.valid <= dv_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mul_ctl_r.status <= dv_ctl.status;
      mul_idx_r        <= dv_idx;
      mul_c0_r         <= dv_c0;
      mul_prod_r       <= prod_nxt;
    end
  end

  assign acc = $signed({2'b00, mul_c0_r, {FRAC_BITS{1'b0}}}) + mul_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= mul_ctl_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r  <= acc[FRAC_BITS +: CELL_W];
      out_idx_r  <= mul_idx_r;
      out_stat_r <= mul_ctl_r.status;
    end
  end

  assign out_bus.valid         = out_vld_r;
  assign out_bus.result        = out_res_r;
  assign out_bus.segment_index = out_idx_r;
  assign out_bus.clamp_status  = out_stat_r;

endmodule
